FILE: hw/rtl/sdtp_pkg.sv
// shared constants, codes and types for the sky dome texcoord projection block
package sdtp_pkg;

    // direction store geometry
    localparam int STORE_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;

    // field widths
    localparam int COORD_W  = 20;
    localparam int SCROLL_W = 15;
    localparam int DIR_W    = 18;
    localparam int TEX_W    = 16;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;

    // arithmetic widths
    localparam int DELTA_W = COORD_W + 1;
    localparam int DZ3_W   = COORD_W + 3;
    localparam int L2_W    = 44;
    localparam int RAD_W   = 60;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SCALE_W = 25;
    localparam int NUM_W   = 47;
    localparam int QUO_W   = DIR_W;

    // 378.0 in Q9.8 and the same times 256
    localparam logic [DIR_W-1:0]   DIR_MAX   = DIR_W'(96768);
    localparam logic [SCALE_W-1:0] DIR_SCALE = SCALE_W'(24772608);

    // vertex commands
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLAY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REWIND  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EYE_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL = 2'd3;

    // one stored direction pair
    typedef struct packed {
        logic signed [DIR_W-1:0] s;
        logic signed [DIR_W-1:0] t;
    } dir_pair_t;

endpackage

FILE: hw/rtl/sdtp_ifs.sv
// valid/ready channel interfaces for vertices, texcoords and configuration
interface sdtp_in_if;
    logic                                valid;
    logic                                ready;
    logic [sdtp_pkg::CMD_W-1:0]          command;
    logic signed [sdtp_pkg::COORD_W-1:0] vertex_x;
    logic signed [sdtp_pkg::COORD_W-1:0] vertex_y;
    logic signed [sdtp_pkg::COORD_W-1:0] vertex_z;

    modport source (output valid, command, vertex_x, vertex_y, vertex_z, input ready);
    modport sink (input valid, command, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface sdtp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sdtp_pkg::TEX_W-1:0] tex_s;
    logic signed [sdtp_pkg::TEX_W-1:0] tex_t;
    logic                              from_store;

    modport source (output valid, tex_s, tex_t, from_store, input ready);
    modport sink (input valid, tex_s, tex_t, from_store, output ready);
endinterface

interface sdtp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sdtp_pkg::CFG_IDX_W-1:0]     index;
    logic [sdtp_pkg::COORD_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sky_dome_texcoord_projection_top.sv
// Sky dome texcoord projection: one vertex in, at most one texcoord pair out.
// A replay of a stored pair goes from acceptance through a store read to the output
// register. A compute passes through one shared squaring multiplier, the 30-step
// bit-pair root and, for each of the two direction parts, a numerator step and the
// 18-step restoring divider, then save and output; with a zero distance the dividers
// are skipped. A stalled output holds the block in its output step. The direction
// store is a single-port-write, registered-read memory of STORE_DEPTH pairs with no
// clearing pass; only one vertex is in flight at a time.
module sky_dome_texcoord_projection_top (
    input  logic         clk,
    input  logic         rst_n,
    sdtp_in_if.sink      vtx,
    sdtp_out_if.source   tex,
    sdtp_cfg_if.sink     cfg
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_SAVE = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    localparam int DW  = sdtp_pkg::DIR_W;
    localparam int AW  = sdtp_pkg::ADDR_W;
    localparam int PW  = sdtp_pkg::POS_W;

    // configuration registers
    logic signed [sdtp_pkg::COORD_W-1:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic [sdtp_pkg::SCROLL_W-1:0]       scroll_reg;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    sq_cnt_reg, sq_cnt_next;
    logic          part_reg, part_next;
    logic          go_reg, go_next;
    logic          save_reg, save_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [sdtp_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [sdtp_pkg::DZ3_W-1:0]   dz3_reg;
    logic [sdtp_pkg::L2_W-1:0]           prod_reg, l2_reg;
    logic [sdtp_pkg::ROOT_W-1:0]         n_reg;
    logic [sdtp_pkg::NUM_W-1:0]          num_reg;
    logic signed [DW-1:0]                dir_s_reg, dir_t_reg;
    logic signed [sdtp_pkg::TEX_W-1:0]   tex_s_reg, tex_t_reg;
    logic                                from_store_reg;

    logic                                accept;
    logic                                avail;
    logic signed [sdtp_pkg::DELTA_W-1:0] dx_w, dy_w;
    logic signed [sdtp_pkg::DZ3_W-1:0]   dz_w, dz3_w, sq_op;
    logic signed [2*sdtp_pkg::DZ3_W-1:0] sq_w;
    logic signed [sdtp_pkg::DELTA_W-1:0] part_d;
    logic [sdtp_pkg::DELTA_W-1:0]        mag_w;
    logic [sdtp_pkg::DELTA_W+sdtp_pkg::SCALE_W-1:0] mp_w;
    logic [sdtp_pkg::QUO_W-1:0]          quo_w, clamp_w;
    logic signed [DW-1:0]                dir_w;
    logic signed [DW:0]                  sum_s, sum_t;

    logic                        sqrt_start, sqrt_done;
    logic [sdtp_pkg::RAD_W-1:0]  sqrt_x;
    logic [sdtp_pkg::ROOT_W-1:0] sqrt_root;
    logic                        div_done;
    logic                        mem_we, mem_re;
    sdtp_pkg::dir_pair_t         mem_wdata, mem_rdata;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg  <= '0;
            eye_y_reg  <= '0;
            eye_z_reg  <= '0;
            scroll_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sdtp_pkg::REG_EYE_X:  eye_x_reg  <= cfg.data;
                sdtp_pkg::REG_EYE_Y:  eye_y_reg  <= cfg.data;
                sdtp_pkg::REG_EYE_Z:  eye_z_reg  <= cfg.data;
                sdtp_pkg::REG_SCROLL: scroll_reg <= cfg.data[sdtp_pkg::SCROLL_W-1:0];
                default:              eye_x_reg  <= eye_x_reg;
            endcase
        end
    end

    // input side
    assign vtx.ready = (state_reg == S_IDLE);
    assign accept    = vtx.valid && vtx.ready;
    assign avail     = !pos_reg[PW-1];

    // eye-relative vector, vertical part tripled
    always_comb
    begin
        dx_w  = sdtp_pkg::DELTA_W'(vtx.vertex_x) - sdtp_pkg::DELTA_W'(eye_x_reg);
        dy_w  = sdtp_pkg::DELTA_W'(vtx.vertex_y) - sdtp_pkg::DELTA_W'(eye_y_reg);
        dz_w  = sdtp_pkg::DZ3_W'(vtx.vertex_z) - sdtp_pkg::DZ3_W'(eye_z_reg);
        dz3_w = dz_w + (dz_w <<< 1);
    end

    // shared squaring multiplier
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_op = sdtp_pkg::DZ3_W'(dx_reg);
            2'd1:    sq_op = sdtp_pkg::DZ3_W'(dy_reg);
            default: sq_op = dz3_reg;
        endcase
        sq_w = sq_op * sq_op;
    end

    assign sqrt_start = (state_reg == S_SQ) && (sq_cnt_reg == 2'd3);
    assign sqrt_x     = {l2_reg + prod_reg, 16'b0};

    // magnitude scaling for the current direction part
    always_comb
    begin
        part_d  = part_reg ? dy_reg : dx_reg;
        mag_w   = part_d[sdtp_pkg::DELTA_W-1] ? sdtp_pkg::DELTA_W'(-part_d)
                                              : sdtp_pkg::DELTA_W'(part_d);
        mp_w    = mag_w * sdtp_pkg::DIR_SCALE;
        clamp_w = (quo_w > sdtp_pkg::DIR_MAX) ? sdtp_pkg::DIR_MAX : quo_w;
        dir_w   = part_d[sdtp_pkg::DELTA_W-1] ? -$signed(clamp_w) : $signed(clamp_w);
    end

    // texcoord rounding, ties toward plus infinity
    always_comb
    begin
        sum_s = $signed({4'b0, scroll_reg}) + (DW + 1)'(dir_s_reg) + (DW + 1)'(4);
        sum_t = $signed({4'b0, scroll_reg}) + (DW + 1)'(dir_t_reg) + (DW + 1)'(4);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sq_cnt_next    = sq_cnt_reg;
        part_next      = part_reg;
        go_next        = 1'b0;
        save_next      = save_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        if (out_valid_reg && tex.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (vtx.command)
                        sdtp_pkg::CMD_REWIND:
                        begin
                            pos_next = '0;
                        end
                        sdtp_pkg::CMD_REPLAY:
                        begin
                            if (avail)
                            begin
                                mem_re     = 1'b1;
                                pos_next   = pos_reg + 1'b1;
                                hit_next   = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                hit_next    = 1'b0;
                                save_next   = 1'b0;
                                sq_cnt_next = '0;
                                state_next  = S_SQ;
                            end
                        end
                        sdtp_pkg::CMD_COMPUTE:
                        begin
                            hit_next    = 1'b0;
                            save_next   = avail;
                            sq_cnt_next = '0;
                            state_next  = S_SQ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_SQ:
            begin
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 2'd3)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    part_next  = 1'b0;
                    state_next = (sqrt_root == '0) ? S_SAVE : S_MUL;
                end
            end
            S_MUL:
            begin
                go_next    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    part_next  = 1'b1;
                    state_next = part_reg ? S_SAVE : S_MUL;
                end
            end
            S_SAVE:
            begin
                if (save_reg)
                begin
                    mem_we   = 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || tex.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            sq_cnt_reg    <= '0;
            part_reg      <= 1'b0;
            go_reg        <= 1'b0;
            save_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sq_cnt_reg    <= sq_cnt_next;
            part_reg      <= part_next;
            go_reg        <= go_next;
            save_reg      <= save_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg  <= dx_w;
            dy_reg  <= dy_w;
            dz3_reg <= dz3_w;
        end
        if (state_reg == S_SQ)
        begin
            prod_reg <= sq_w[sdtp_pkg::L2_W-1:0];
            l2_reg   <= (sq_cnt_reg == 2'd0) ? '0 : l2_reg + prod_reg;
        end
        if ((state_reg == S_SQRT) && sqrt_done)
        begin
            n_reg <= sqrt_root;
            if (sqrt_root == '0)
            begin
                dir_s_reg <= '0;
                dir_t_reg <= '0;
            end
        end
        if (state_reg == S_MUL)
        begin
            num_reg <= sdtp_pkg::NUM_W'(mp_w) + sdtp_pkg::NUM_W'(n_reg >> 1);
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            if (part_reg)
            begin
                dir_t_reg <= dir_w;
            end
            else
            begin
                dir_s_reg <= dir_w;
            end
        end
        if (state_reg == S_READ)
        begin
            dir_s_reg <= mem_rdata.s;
            dir_t_reg <= mem_rdata.t;
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || tex.ready))
        begin
            tex_s_reg      <= sum_s[DW:3];
            tex_t_reg      <= sum_t[DW:3];
            from_store_reg <= hit_reg;
        end
    end

    // output register
    assign tex.valid      = out_valid_reg;
    assign tex.tex_s      = tex_s_reg;
    assign tex.tex_t      = tex_t_reg;
    assign tex.from_store = from_store_reg;

    assign mem_wdata.s = dir_s_reg;
    assign mem_wdata.t = dir_t_reg;

    sdtp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_x),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    sdtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .numer    (num_reg),
        .denom    (n_reg),
        .done     (div_done),
        .quotient (quo_w)
    );

    sdtp_store u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (pos_reg[AW-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (pos_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    // position never passes the end of the store
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(sdtp_pkg::STORE_DEPTH))
    else $error("store position beyond depth");

    // a save only happens while the store has room
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !pos_reg[PW-1])
    else $error("store write while full");

    // root result only arrives while waiting for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == S_SQRT))
    else $error("unexpected root completion");

    // a replay hit reads the store and then presents the pair
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == S_READ) && hit_reg)
    else $error("replay read not followed by read state");

    // quotient only arrives while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
    else $error("unexpected divider completion");
`endif

endmodule

FILE: hw/rtl/sdtp_store.sv
// direction pair store, one write port and one registered read port
module sdtp_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [sdtp_pkg::ADDR_W-1:0] wr_addr,
    input  sdtp_pkg::dir_pair_t         wr_data,
    input  logic                        rd_en,
    input  logic [sdtp_pkg::ADDR_W-1:0] rd_addr,
    output sdtp_pkg::dir_pair_t         rd_data
);

    sdtp_pkg::dir_pair_t mem [sdtp_pkg::STORE_DEPTH];
    sdtp_pkg::dir_pair_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sdtp_sqrt.sv
// bit-pair integer square root, one result bit per cycle
module sdtp_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sdtp_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [sdtp_pkg::ROOT_W-1:0] root
);

    localparam int W = sdtp_pkg::RAD_W;

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] bit_reg, bit_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W:0]   trial;

    // one iteration of the root recurrence
    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, acc_reg} + {1'b0, bit_reg};
        if (start)
        begin
            rem_next  = radicand;
            acc_next  = '0;
            bit_next  = W'(1) << (W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[W-1:0];
                acc_next = (acc_reg >> 1) + bit_reg;
            end
            else
            begin
                acc_next = acc_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = acc_reg[sdtp_pkg::ROOT_W-1:0];

endmodule

FILE: hw/rtl/sdtp_div.sv
// restoring divider with saturating quotient, one quotient bit per cycle
module sdtp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sdtp_pkg::NUM_W-1:0]  numer,
    input  logic [sdtp_pkg::ROOT_W-1:0] denom,
    output logic                        done,
    output logic [sdtp_pkg::QUO_W-1:0]  quotient
);

    localparam int NW  = sdtp_pkg::NUM_W;
    localparam int QW  = sdtp_pkg::QUO_W;
    localparam int CW  = $clog2(QW + 1);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sat_reg, sat_next;
    logic          done_reg, done_next;

    // load or shift-subtract step
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = numer;
            den_next = NW'({denom, {(QW - 1){1'b0}}});
            quo_next = '0;
            cnt_next = CW'(QW);
            sat_next = {1'b0, numer} >= (NW + 1)'({denom, {QW{1'b0}}});
        end
        else if (cnt_reg != '0)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_next = rem_reg - den_reg;
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? '1 : quo_reg;

endmodule
